// File: sv/b64se_pkg.sv
// ----------------------------------------------------------------------------
// b64se_pkg
// shared types, constants and the sextet-to-character mapping for the
// base64 stream encoder
// ----------------------------------------------------------------------------
package b64se_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } t_out_word;

    // one complete or final group handed from front to back
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad_count;
        logic        last;
    } t_group;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'd97 + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 7'd48 + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 7'd43;
        end else begin
            c = 7'd47;
        end
        return c;
    endfunction

endpackage

// File: sv/b64se_front.sv
// ----------------------------------------------------------------------------
// b64se_front
// accepts input words, collects bytes into groups of three and hands a
// group to the queue when it is full or the message ends
// ----------------------------------------------------------------------------
module b64se_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  b64se_pkg::t_in_word  i_data,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output b64se_pkg::t_group    o_group
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [7:0] r_byte0;
    logic [7:0] r_byte1;
    logic       accept;
    logic       emit;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign emit    = (r_count == 2'd2) || i_data.end_of_message;
    assign o_push  = accept && emit;

    always_comb begin
        o_group.last = i_data.end_of_message;
        case (r_count)
            2'd0: begin
                o_group.bits      = {i_data.data_byte, 16'd0};
                o_group.pad_count = 2'd2;
            end
            2'd1: begin
                o_group.bits      = {r_byte0, i_data.data_byte, 8'd0};
                o_group.pad_count = 2'd1;
            end
            default: begin
                o_group.bits      = {r_byte0, r_byte1, i_data.data_byte};
                o_group.pad_count = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = emit ? 2'd0 : r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !emit) begin
            if (r_count == 2'd0) begin
                r_byte0 <= i_data.data_byte;
            end else begin
                r_byte1 <= i_data.data_byte;
            end
        end
    end

endmodule

// File: sv/b64se_queue.sv
// ----------------------------------------------------------------------------
// b64se_queue
// small first-in first-out queue of groups between front and back
// ----------------------------------------------------------------------------
module b64se_queue #(
    parameter int DEPTH = b64se_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64se_pkg::t_group i_group,
    input  logic              i_pop,
    output b64se_pkg::t_group o_group,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    b64se_pkg::t_group r_mem [DEPTH];
    logic [AW:0] r_wr_ptr;
    logic [AW:0] r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_group = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_group;
        end
    end

endmodule

// File: sv/b64se_back.sv
// ----------------------------------------------------------------------------
// b64se_back
// takes groups from the queue and sends their four characters, one word
// per cycle unless the output stalls, through an output register
// ----------------------------------------------------------------------------
module b64se_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_queue_empty,
    input  b64se_pkg::t_group    i_group,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64se_pkg::t_out_word o_data
);

    logic                 r_busy;
    logic [1:0]           r_idx;
    b64se_pkg::t_group    r_grp;
    logic                 r_out_valid;
    b64se_pkg::t_out_word r_out;
    b64se_pkg::t_out_word n_out;
    logic                 load_out;
    logic                 final_char;
    logic [5:0]           sextet;

    assign load_out   = r_busy && (!r_out_valid || i_ready);
    assign final_char = (r_idx == 2'd3);
    assign o_pop      = !i_queue_empty && (!r_busy || (load_out && final_char));
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
        if ({1'b0, r_idx} >= 3'd4 - {1'b0, r_grp.pad_count}) begin
            n_out.out_char = b64se_pkg::PAD_CHAR;
        end else begin
            n_out.out_char = b64se_pkg::sextet_char(sextet);
        end
        n_out.out_last = final_char && r_grp.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (load_out) begin
                r_idx <= r_idx + 2'd1;
                if (final_char) begin
                    r_busy <= 1'b0;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

// File: sv/base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// streaming base64 encoder, standard alphabet with '=' padding
//
// input channel: one raw byte per word with an end-of-message flag
// (i_valid / o_ready). output channel: one ascii character per word with
// a last flag on the final character of the message (o_valid / i_ready).
// every third byte, and every byte flagged end of message, closes a group
// that yields four characters; groups wait in a small queue between the
// byte collector and the character sequencer.
// the byte that closes a group is written into the queue; the group then
// moves into the sequencer's group register, and its first character into
// the output register. throughput: one character per cycle while i_ready
// is high, set by the single-character output register; every three bytes
// yield four characters, and a final one or two bytes still yield four.
// reset clears the byte count, the queue, the sequencer state and the output valid flag.
// a stall on the output holds the current character; the queue then fills
// and o_ready drops until room frees up again.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  b64se_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64se_pkg::t_out_word o_data
);

    b64se_pkg::t_group push_group;
    b64se_pkg::t_group head_group;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;

    b64se_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_group      (push_group)
    );

    b64se_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .i_pop   (pop),
        .o_group (head_group),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    b64se_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_group       (head_group),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for base64_stream_encoder_core: a queued byte driver and
// a character monitor with random gaps and output stalls; every accepted byte
// feeds a local group encoder whose characters are matched in order
// ----------------------------------------------------------------------------
module tb;

    localparam logic [0:63][7:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_ready = 1'b0;
    b64se_pkg::t_in_word  i_data  = '0;
    logic                 o_ready;
    logic                 o_valid;
    b64se_pkg::t_out_word o_data;

    b64se_pkg::t_in_word  byte_queue[$];
    b64se_pkg::t_out_word expected_chars[$];

    logic [7:0] held_bytes[2];
    logic [1:0] held_count;

    logic        in_taken;
    int unsigned items_taken = 0;
    int unsigned total_items = 0;
    int unsigned error_count = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    logic        calm;

    base64_stream_encoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // no idling on either side in every third stretch of 25 bytes
    assign calm = ((items_taken / 25) % 3) == 2;

    function automatic logic [6:0] b64_symbol(input logic [5:0] v);
        return ALPHABET[v][6:0];
    endfunction

    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic encode_byte(input b64se_pkg::t_in_word w);
        logic [23:0]          grp;
        int                   pad_n;
        b64se_pkg::t_out_word ch;
        if (held_count < 2'd2 && !w.end_of_message) begin
            held_bytes[held_count[0]] = w.data_byte;
            held_count = held_count + 2'd1;
        end else begin
            case (held_count)
                2'd0: begin
                    grp   = {w.data_byte, 16'h0000};
                    pad_n = 2;
                end
                2'd1: begin
                    grp   = {held_bytes[0], w.data_byte, 8'h00};
                    pad_n = 1;
                end
                default: begin
                    grp   = {held_bytes[0], held_bytes[1], w.data_byte};
                    pad_n = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                ch.out_char = (k >= 4 - pad_n) ? b64se_pkg::PAD_CHAR
                                               : b64_symbol(grp[23 - 6 * k -: 6]);
                ch.out_last = (k == 3) && w.end_of_message;
                expected_chars.push_back(ch);
            end
            held_count = 2'd0;
        end
    endtask

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_message(input logic [7:0] b[$]);
        b64se_pkg::t_in_word w;
        foreach (b[i]) begin
            w.data_byte      = b[i];
            w.end_of_message = (i == b.size() - 1);
            byte_queue.push_back(w);
            total_items++;
        end
    endtask

    // byte driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && in_taken) begin
                gap_left = next_gap();
            end
            if (i_valid && !in_taken) begin
                i_valid <= 1'b1;
            end else if (gap_left != 0) begin
                i_valid  <= 1'b0;
                gap_left = gap_left - 1;
            end else if (byte_queue.size() != 0) begin
                i_data  <= byte_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // character receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left != 0) begin
            i_ready    <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_ready    <= 1'b1;
            stall_left = next_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        b64se_pkg::t_out_word want;
        if (!i_rst_n) begin
            in_taken   <= 1'b0;
            held_count = 2'd0;
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
        end else begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                encode_byte(i_data);
                items_taken++;
            end
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    report("unexpected word, char", o_data.out_char, 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_data.out_char !== want.out_char) begin
                        report("out_char", o_data.out_char, want.out_char);
                    end
                    if (o_data.out_last !== want.out_last) begin
                        report("out_last", o_data.out_last, want.out_last);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned       len;
        int unsigned       rnd_items;
        logic [7:0]        msg[$];
        msg = '{8'h00};                             add_message(msg);
        msg = '{8'hFF};                             add_message(msg);
        msg = '{8'hFF, 8'hFF};                      add_message(msg);
        msg = '{8'h00, 8'h00, 8'h00};               add_message(msg);
        msg = '{8'hFB, 8'hEF, 8'hBE};               add_message(msg);
        msg = '{8'hFF, 8'hFF, 8'hFF};               add_message(msg);
        msg = '{8'h4D, 8'h61, 8'h6E, 8'h61};        add_message(msg);
        msg = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}; add_message(msg);
        rnd_items = 0;
        while (rnd_items < 95) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            msg.delete();
            repeat (len) msg.push_back(8'($urandom_range(0, 255)));
            add_message(msg);
            rnd_items += len;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken != total_items) @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
sv/b64se_pkg.sv
sv/b64se_front.sv
sv/b64se_queue.sv
sv/b64se_back.sv
sv/base64_stream_encoder_core.sv
sim/tb.sv
